// ===== hdl/gtr_pkg.sv =====
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, character codes and helpers for the wildcard-to-regex
// translator.
// ----------------------------------------------------------------------------
package gtr_pkg;

    // Most bytes one word can expand to, and the width of a byte count
    localparam int MAX_RESULTS = 7;
    localparam int CNT_W       = 3;

    // Default brace nesting counter width
    localparam int BRACE_DEPTH_BITS_DEF = 8;

    // Character codes
    localparam logic [7:0] CH_BSL    = 8'h5C; // backslash
    localparam logic [7:0] CH_UP_A   = 8'h41; // A
    localparam logic [7:0] CH_LO_Z   = 8'h7A; // z
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_BANG   = 8'h21;

    // Expansion of one word, slot 0 goes out first
    typedef logic [MAX_RESULTS-1:0][7:0] res_bytes_t;

    // Parser flags carried from word to word
    typedef struct packed {
        logic       escape_pending;
        logic       inside_class;
        logic [1:0] class_position;
        logic       class_lead_negation;
    } gtr_flags_t;

    // ASCII punctuation test
    function automatic logic is_punct(input logic [7:0] c);
        is_punct = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                   (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

endpackage

// ===== hdl/glob_to_regex_translator_core.sv =====
// ----------------------------------------------------------------------------
// glob_to_regex_translator_core
// The bytes of an accepted word are registered into the active slot, or
// into the spare slot while the active one drains. Throughput: one output
// byte per cycle while m_tready is high; a word with no bytes never
// uses the output port. The single output byte port sets the rate.
// Reset: aresetn (synchronous) clears parser state and both output slots.
// ----------------------------------------------------------------------------
module glob_to_regex_translator_core
    import gtr_pkg::*;
#(
    parameter int BRACE_DEPTH_BITS = BRACE_DEPTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pattern_byte
    input  logic       s_tlast,   // last_item
    input  logic [1:0] s_tuser,   // [0] first_item, [1] no_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    gtr_flags_t                  flags_reg, flags_next, flags_exp;
    logic [BRACE_DEPTH_BITS-1:0] depth_reg, depth_next, depth_exp;
    res_bytes_t                  exp_bytes;
    logic [CNT_W-1:0]            exp_count;

    // Active slot drains to the output, spare slot holds the next word
    res_bytes_t       a_bytes_reg, a_bytes_next, b_bytes_reg, b_bytes_next;
    logic [CNT_W-1:0] a_cnt_reg, a_cnt_next, b_cnt_reg, b_cnt_next;
    logic [CNT_W-1:0] a_idx_reg, a_idx_next;
    logic             a_valid_reg, a_valid_next, b_valid_reg, b_valid_next;

    logic accept, load, out_fire, a_last, a_free;

    gtr_expand #(
        .BRACE_DEPTH_BITS (BRACE_DEPTH_BITS)
    ) u_expand (
        .pattern_byte (s_tdata),
        .first_item   (s_tuser[0]),
        .last_item    (s_tlast),
        .no_byte      (s_tuser[1]),
        .flags_in     (flags_reg),
        .depth_in     (depth_reg),
        .flags_out    (flags_exp),
        .depth_out    (depth_exp),
        .res_bytes    (exp_bytes),
        .res_count    (exp_count)
    );

    // Handshake
    assign s_tready = !b_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign load     = accept && (exp_count != '0);
    assign m_tvalid = a_valid_reg;
    assign m_tdata  = a_bytes_reg[a_idx_reg];
    assign a_last   = (a_idx_reg == a_cnt_reg - CNT_W'(1));
    assign m_tlast  = a_last;
    assign out_fire = a_valid_reg && m_tready;
    assign a_free   = !a_valid_reg || (out_fire && a_last);

    // Advance parser state on every accepted word
    assign flags_next = accept ? flags_exp : flags_reg;
    assign depth_next = accept ? depth_exp : depth_reg;

    // Slot bookkeeping
    always_comb begin
        a_bytes_next = a_bytes_reg;
        a_cnt_next   = a_cnt_reg;
        a_idx_next   = a_idx_reg;
        a_valid_next = a_valid_reg;
        b_bytes_next = b_bytes_reg;
        b_cnt_next   = b_cnt_reg;
        b_valid_next = b_valid_reg;
        if (a_free) begin
            a_idx_next = '0;
            if (b_valid_reg) begin
                a_bytes_next = b_bytes_reg;
                a_cnt_next   = b_cnt_reg;
                a_valid_next = 1'b1;
                b_valid_next = 1'b0;
            end else begin
                a_bytes_next = exp_bytes;
                a_cnt_next   = exp_count;
                a_valid_next = load;
            end
        end else begin
            if (out_fire) begin
                a_idx_next = a_idx_reg + CNT_W'(1);
            end
            if (load) begin
                b_bytes_next = exp_bytes;
                b_cnt_next   = exp_count;
                b_valid_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= '0;
            depth_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            a_idx_reg   <= '0;
        end else begin
            flags_reg   <= flags_next;
            depth_reg   <= depth_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            a_idx_reg   <= a_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_bytes_reg <= a_bytes_next;
        a_cnt_reg   <= a_cnt_next;
        b_bytes_reg <= b_bytes_next;
        b_cnt_reg   <= b_cnt_next;
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> (a_idx_reg < a_cnt_reg))
        else $error("output index past byte count");

    a_slot_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> (a_cnt_reg != '0))
        else $error("active slot holds no bytes");

    spare_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> a_valid_reg)
        else $error("spare slot filled while active slot empty");

    idx_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (a_valid_reg && (a_idx_reg == $past(a_idx_reg) + CNT_W'(1))))
        else $error("output index did not advance by one");
`endif

endmodule

// ===== hdl/gtr_expand.sv =====
// ----------------------------------------------------------------------------
// gtr_expand
// Combinational expansion of one pattern word into up to seven regex bytes,
// together with the parser state left behind.
// ----------------------------------------------------------------------------
module gtr_expand
    import gtr_pkg::*;
#(
    parameter int BRACE_DEPTH_BITS = BRACE_DEPTH_BITS_DEF
) (
    input  logic [7:0]                  pattern_byte,
    input  logic                        first_item,
    input  logic                        last_item,
    input  logic                        no_byte,
    input  gtr_flags_t                  flags_in,
    input  logic [BRACE_DEPTH_BITS-1:0] depth_in,
    output gtr_flags_t                  flags_out,
    output logic [BRACE_DEPTH_BITS-1:0] depth_out,
    output res_bytes_t                  res_bytes,
    output logic [CNT_W-1:0]            res_count
);

    res_bytes_t                  b;
    logic [CNT_W-1:0]            n;
    gtr_flags_t                  f;
    logic [BRACE_DEPTH_BITS-1:0] d;
    logic [1:0]                  pos;
    logic [7:0]                  c;

    // Walk the word: start marker, byte, end marker
    always_comb begin
        b   = '0;
        n   = '0;
        f   = flags_in;
        d   = depth_in;
        c   = pattern_byte;
        pos = '0;

        if (first_item) begin
            f = '0;
            d = '0;
            b[n] = CH_BSL;  n = n + CNT_W'(1);
            b[n] = CH_UP_A; n = n + CNT_W'(1);
        end

        if (!no_byte) begin
            pos = f.class_position;
            if (f.escape_pending) begin
                // Keep the escaped byte, quote it only if punctuation
                f.escape_pending = 1'b0;
                if (is_punct(c)) begin
                    b[n] = CH_BSL; n = n + CNT_W'(1);
                end
                b[n] = c; n = n + CNT_W'(1);
                if (f.inside_class && pos != 2'd2) begin
                    f.class_position = pos + 2'd1;
                end
            end else if (c == CH_BSL) begin
                f.escape_pending = 1'b1;
                if (f.inside_class) begin
                    if (pos == 2'd0) begin
                        f.class_lead_negation = 1'b0;
                    end
                    if (pos != 2'd2) begin
                        f.class_position = pos + 2'd1;
                    end
                end
            end else if (f.inside_class) begin
                // Class body
                if (c == CH_RBRK) begin
                    b[n] = CH_RBRK; n = n + CNT_W'(1);
                    if (!(pos == 2'd0 || (pos == 2'd1 && f.class_lead_negation))) begin
                        f.inside_class = 1'b0;
                    end
                end else if (c == CH_BANG) begin
                    b[n] = (pos == 2'd0) ? CH_CARET : CH_BANG; n = n + CNT_W'(1);
                end else begin
                    b[n] = c; n = n + CNT_W'(1);
                end
                if (pos == 2'd0) begin
                    f.class_lead_negation = (c == CH_BANG) || (c == CH_CARET);
                end
                if (pos != 2'd2) begin
                    f.class_position = pos + 2'd1;
                end
            end else begin
                // Plain text
                case (c)
                    CH_STAR: begin
                        b[n] = CH_DOT;  n = n + CNT_W'(1);
                        b[n] = CH_STAR; n = n + CNT_W'(1);
                    end
                    CH_QUEST: begin
                        b[n] = CH_DOT; n = n + CNT_W'(1);
                    end
                    CH_LBRK: begin
                        b[n] = CH_LBRK; n = n + CNT_W'(1);
                        f.inside_class        = 1'b1;
                        f.class_position      = 2'd0;
                        f.class_lead_negation = 1'b0;
                    end
                    CH_LBRACE: begin
                        b[n] = CH_LPAREN; n = n + CNT_W'(1);
                        b[n] = CH_QUEST;  n = n + CNT_W'(1);
                        b[n] = CH_COLON;  n = n + CNT_W'(1);
                        if (!(&d)) begin
                            d = d + BRACE_DEPTH_BITS'(1);
                        end
                    end
                    CH_RBRACE: begin
                        b[n] = CH_RPAREN; n = n + CNT_W'(1);
                        if (d != '0) begin
                            d = d - BRACE_DEPTH_BITS'(1);
                        end
                    end
                    CH_COMMA: begin
                        b[n] = (d != '0) ? CH_PIPE : CH_COMMA; n = n + CNT_W'(1);
                    end
                    CH_CARET, CH_DOLLAR, CH_DOT, CH_PLUS,
                    CH_LPAREN, CH_RPAREN, CH_PIPE: begin
                        b[n] = CH_BSL; n = n + CNT_W'(1);
                        b[n] = c;      n = n + CNT_W'(1);
                    end
                    default: begin
                        b[n] = c; n = n + CNT_W'(1);
                    end
                endcase
            end
        end

        if (last_item) begin
            // Dangling backslash turns into a literal one
            if (f.escape_pending) begin
                b[n] = CH_BSL; n = n + CNT_W'(1);
                b[n] = CH_BSL; n = n + CNT_W'(1);
            end
            b[n] = CH_BSL;  n = n + CNT_W'(1);
            b[n] = CH_LO_Z; n = n + CNT_W'(1);
            f = '0;
            d = '0;
        end
    end

    assign res_bytes = b;
    assign res_count = n;
    assign flags_out = f;
    assign depth_out = d;

endmodule
